[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define AST_PROP(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define AST_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define AST_PROP(name, clk, rstn, prop)
`define AST_NEVER(name, clk, rstn, cond)

`endif

`endif

[design/cbp_pkg.sv]
// ----------------------------------------------------------------------------
// cbp_pkg
// Constants and types shared by the CSV field parser files.
// ----------------------------------------------------------------------------
package cbp_pkg;

    // Default parameter values.
    localparam int INDEX_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 12;

    // Field and register widths.
    localparam int BYTE_BITS     = 8;
    localparam int MAXCH_BITS    = 12;
    localparam int GRID_BITS     = 16;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_FIELD_CHARS = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GRID_ROWS       = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GRID_COLS       = 2'd2;

    // Configuration reset values.
    localparam logic [MAXCH_BITS-1:0] MAX_FIELD_CHARS_RST = 12'd255;
    localparam logic [GRID_BITS-1:0]  GRID_ROWS_RST       = 16'd100;
    localparam logic [GRID_BITS-1:0]  GRID_COLS_RST       = 16'd26;

    // Special characters.
    localparam logic [BYTE_BITS-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_BITS-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;

    // Per-transaction result flags.
    typedef struct packed {
        logic char_valid;
        logic field_end;
        logic field_empty;
        logic row_end;
        logic input_end;
        logic in_grid;
    } t_flags;

endpackage

[design/cbp_in_if.sv]
// ----------------------------------------------------------------------------
// cbp_in_if
// Byte channel into the CSV field parser.
// ----------------------------------------------------------------------------
interface cbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_mark;

    modport source (output valid, output data_byte, output end_mark, input ready);
    modport sink   (input valid, input data_byte, input end_mark, output ready);
endinterface

[design/cbp_out_if.sv]
// ----------------------------------------------------------------------------
// cbp_out_if
// Result channel out of the CSV field parser.
// ----------------------------------------------------------------------------
interface cbp_out_if #(
    parameter int INDEX_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [7:0]            char_out;
    logic                  char_valid;
    logic                  field_end;
    logic                  field_empty;
    logic                  row_end;
    logic                  input_end;
    logic [INDEX_BITS-1:0] row_index;
    logic [INDEX_BITS-1:0] col_index;
    logic                  in_grid;

    modport source (
        output valid, output char_out, output char_valid, output field_end,
        output field_empty, output row_end, output input_end, output row_index,
        output col_index, output in_grid, input ready
    );
    modport sink (
        input valid, input char_out, input char_valid, input field_end,
        input field_empty, input row_end, input input_end, input row_index,
        input col_index, input in_grid, output ready
    );
endinterface

[design/cbp_parser.sv]
// ----------------------------------------------------------------------------
// cbp_parser
// Parser state, field character count and row/column counters. Computes the
// result of the presented byte and advances its state when it is accepted.
// ----------------------------------------------------------------------------
module cbp_parser #(
    parameter int INDEX_BITS = 16,
    parameter int COUNT_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_end_mark,
    input  logic [cbp_pkg::MAXCH_BITS-1:0] i_max_field_chars,
    input  logic [cbp_pkg::GRID_BITS-1:0]  i_grid_rows,
    input  logic [cbp_pkg::GRID_BITS-1:0]  i_grid_cols,
    output logic [7:0]                     o_char_out,
    output cbp_pkg::t_flags                o_flags,
    output logic [INDEX_BITS-1:0]          o_row_index,
    output logic [INDEX_BITS-1:0]          o_col_index
);
    import cbp_pkg::*;

    localparam int CNT_CMP_BITS  = (COUNT_BITS > MAXCH_BITS) ? COUNT_BITS : MAXCH_BITS;
    localparam int GRID_CMP_BITS = (INDEX_BITS > GRID_BITS) ? INDEX_BITS : GRID_BITS;

    typedef enum logic [2:0] {
        ST_START,
        ST_PLAIN,
        ST_QUOTED,
        ST_QSEEN,
        ST_QCR
    } t_state;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [INDEX_BITS-1:0] r_row, n_row;
    logic [INDEX_BITS-1:0] r_col, n_col;

    logic store_req;
    logic can_store;
    logic char_ok;
    logic fend;
    logic rend;
    logic empty;

    assign can_store = (CNT_CMP_BITS'(r_count) < CNT_CMP_BITS'(i_max_field_chars))
                       && (r_count != '1);
    assign char_ok   = store_req && can_store;
    assign empty     = (r_count == '0);

    always_comb begin
        n_state   = r_state;
        store_req = 1'b0;
        fend      = 1'b0;
        rend      = 1'b0;
        if (i_end_mark) begin
            if (r_state != ST_START) begin
                fend = 1'b1;
                // An unterminated quoted field does not close its row.
                rend = (r_state != ST_QUOTED);
            end
        end else begin
            case (r_state)
                ST_START, ST_PLAIN: begin
                    if (r_state == ST_START && i_data_byte == CH_QUOTE) begin
                        n_state = ST_QUOTED;
                    end else if (i_data_byte == CH_COMMA) begin
                        fend = 1'b1;
                    end else if (i_data_byte == CH_LF) begin
                        fend = 1'b1;
                        rend = 1'b1;
                    end else if (i_data_byte == CH_CR) begin
                        n_state = ST_PLAIN;
                    end else begin
                        store_req = 1'b1;
                        n_state   = ST_PLAIN;
                    end
                end
                ST_QUOTED: begin
                    if (i_data_byte == CH_QUOTE) begin
                        n_state = ST_QSEEN;
                    end else begin
                        store_req = 1'b1;
                    end
                end
                ST_QSEEN: begin
                    if (i_data_byte == CH_QUOTE) begin
                        store_req = 1'b1;
                        n_state   = ST_QUOTED;
                    end else if (i_data_byte == CH_CR) begin
                        n_state = ST_QCR;
                    end else begin
                        fend = 1'b1;
                        rend = (i_data_byte == CH_LF);
                    end
                end
                default: begin
                    fend = 1'b1;
                    rend = (i_data_byte == CH_LF);
                end
            endcase
        end
        // A finished field or the end of input returns the parser to field start.
        if (fend || i_end_mark) begin
            n_state = ST_START;
        end
    end

    always_comb begin
        n_count = char_ok ? r_count + 1'b1 : r_count;
        n_row   = r_row;
        n_col   = r_col;
        if (fend) begin
            n_count = '0;
            if (rend) begin
                n_row = (r_row != '1) ? r_row + 1'b1 : r_row;
                n_col = '0;
            end else begin
                n_col = (r_col != '1) ? r_col + 1'b1 : r_col;
            end
        end
        if (i_end_mark) begin
            n_count = '0;
            n_row   = '0;
            n_col   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_count <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_count <= n_count;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    assign o_char_out          = char_ok ? i_data_byte : 8'h00;
    assign o_flags.char_valid  = char_ok;
    assign o_flags.field_end   = fend;
    assign o_flags.field_empty = fend && empty;
    assign o_flags.row_end     = rend;
    assign o_flags.input_end   = i_end_mark;
    assign o_flags.in_grid     = fend && !empty
                                 && (GRID_CMP_BITS'(r_row) < GRID_CMP_BITS'(i_grid_rows))
                                 && (GRID_CMP_BITS'(r_col) < GRID_CMP_BITS'(i_grid_cols));
    assign o_row_index         = r_row;
    assign o_col_index         = r_col;

endmodule

[design/csv_byte_stream_field_parser.sv]
// ----------------------------------------------------------------------------
// csv_byte_stream_field_parser
// CSV byte parser reporting stored characters, field and row boundaries.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction carries
//  i_byte    in         data_byte, end_mark
//  o_field   out        char_out, flags, row_index, col_index, in_grid
//  i_cfg_*   in         register index and data, one write per cycle
//
//  One byte per cycle while the output is not stalled: the parser state update
//  and the result are one level of logic from the state registers into the
//  output register. A result appears in the cycle after its byte is accepted.
//  i_byte.ready stays high while the output register is empty or being taken.
//  Synchronous reset clears parser state and counters, loads config defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csv_byte_stream_field_parser #(
    parameter int INDEX_BITS = cbp_pkg::INDEX_BITS_DEF,
    parameter int COUNT_BITS = cbp_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbp_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [cbp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    cbp_in_if.sink                            i_byte,
    cbp_out_if.source                         o_field
);
    import cbp_pkg::*;

    logic [MAXCH_BITS-1:0] r_max_field_chars;
    logic [GRID_BITS-1:0]  r_grid_rows;
    logic [GRID_BITS-1:0]  r_grid_cols;

    logic                  r_out_valid;
    logic [7:0]            r_char;
    t_flags                r_flags;
    logic [INDEX_BITS-1:0] r_row;
    logic [INDEX_BITS-1:0] r_col;

    logic                  in_ready;
    logic                  in_accept;
    logic [7:0]            n_char;
    t_flags                n_flags;
    logic [INDEX_BITS-1:0] n_row;
    logic [INDEX_BITS-1:0] n_col;

    assign in_ready  = !r_out_valid || o_field.ready;
    assign in_accept = i_byte.valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_field_chars <= MAX_FIELD_CHARS_RST;
            r_grid_rows       <= GRID_ROWS_RST;
            r_grid_cols       <= GRID_COLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_FIELD_CHARS: r_max_field_chars <= i_cfg_data[MAXCH_BITS-1:0];
                CFG_GRID_ROWS:       r_grid_rows       <= i_cfg_data[GRID_BITS-1:0];
                CFG_GRID_COLS:       r_grid_cols       <= i_cfg_data[GRID_BITS-1:0];
                default: ;
            endcase
        end
    end

    cbp_parser #(
        .INDEX_BITS (INDEX_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_data_byte       (i_byte.data_byte),
        .i_end_mark        (i_byte.end_mark),
        .i_max_field_chars (r_max_field_chars),
        .i_grid_rows       (r_grid_rows),
        .i_grid_cols       (r_grid_cols),
        .o_char_out        (n_char),
        .o_flags           (n_flags),
        .o_row_index       (n_row),
        .o_col_index       (n_col)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_field.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_char  <= n_char;
            r_flags <= n_flags;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    assign i_byte.ready        = in_ready;
    assign o_field.valid       = r_out_valid;
    assign o_field.char_out    = r_char;
    assign o_field.char_valid  = r_flags.char_valid;
    assign o_field.field_end   = r_flags.field_end;
    assign o_field.field_empty = r_flags.field_empty;
    assign o_field.row_end     = r_flags.row_end;
    assign o_field.input_end   = r_flags.input_end;
    assign o_field.row_index   = r_row;
    assign o_field.col_index   = r_col;
    assign o_field.in_grid     = r_flags.in_grid;

    // An end mark always yields a result flagged as the end of input.
    `AST_PROP(a_end_reported, i_clk, i_rst_n, (in_accept && i_byte.end_mark) |=> (r_out_valid && r_flags.input_end))
    // A stored character never coincides with a field boundary.
    `AST_NEVER(a_char_not_at_end, i_clk, i_rst_n, r_out_valid && r_flags.char_valid && r_flags.field_end)
    // Row end, empty and in-grid are only reported with a field end.
    `AST_NEVER(a_flags_need_end, i_clk, i_rst_n, r_out_valid && !r_flags.field_end && (r_flags.row_end || r_flags.field_empty || r_flags.in_grid))
    // An in-grid field is never empty.
    `AST_NEVER(a_grid_not_empty, i_clk, i_rst_n, r_out_valid && r_flags.in_grid && r_flags.field_empty)

endmodule
